[rtl/c2p_pkg.sv]
// Shared types and constants for the Cartesian-to-polar cell binning block.
// Holds register indexes, the CORDIC arctangent table and pipeline control types.
// No dependencies.
package c2p_pkg;

    localparam int TURN_BITS   = 32;
    localparam int PRESCALE_SH = 24;
    localparam int TABLE_LEN   = 24;
    localparam int NUM_W       = 42;
    localparam int DEN_W       = 33;
    localparam int OUT_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd4;

    localparam logic [15:0] RST_ROTATION   = 16'd0;
    localparam logic [15:0] RST_HALF_WIDTH = 16'd8192;
    localparam logic [14:0] RST_OUTER_RAD  = 15'd16384;
    localparam logic [8:0]  RST_COLUMNS    = 9'd64;
    localparam logic [8:0]  RST_ROWS       = 9'd64;

    // atan(2^-i) on a full-turn scale of 2^32.
    localparam logic [TURN_BITS-1:0] ATAN_TURN [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_LOW,
        SAT_HIGH
    } t_sat;

    typedef struct packed {
        logic adv;
        logic vld;
    } t_ctl;

endpackage

[rtl/c2p_in_if.sv]
// Input channel carrying one Cartesian point per transaction.
// Depends on nothing.
interface c2p_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_pos;
    logic signed [COORD_BITS-1:0] y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

[rtl/c2p_out_if.sv]
// Output channel carrying one grid cell result per transaction.
// Depends on nothing.
interface c2p_out_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] column;
    logic signed [9:0] ring;
    logic              inside_res;

    modport source (output valid, output column, output ring, output inside_res, input ready);
    modport sink   (input valid, input column, input ring, input inside_res, output ready);
endinterface

[rtl/c2p_cfg_if.sv]
// Configuration write channel: register index and write data per transaction.
// Depends on nothing.
interface c2p_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/c2p_cell.sv]
// One cell of the angle and radius chain: a CORDIC vectoring step and one
// bit of the integer square root. Depends on c2p_pkg.
module c2p_cell #(
    parameter int IDX           = 0,
    parameter int COORD_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int CW            = 43
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  c2p_pkg::t_ctl               i_ctl,
    input  logic signed [CW-1:0]        i_u,
    input  logic signed [CW-1:0]        i_v,
    input  logic [31:0]                 i_z,
    input  logic [2*COORD_BITS-1:0]     i_rem,
    input  logic [COORD_BITS-1:0]       i_root,
    input  logic                        i_org,
    output logic                        o_vld,
    output logic signed [CW-1:0]        o_u,
    output logic signed [CW-1:0]        o_v,
    output logic [31:0]                 o_z,
    output logic [2*COORD_BITS-1:0]     o_rem,
    output logic [COORD_BITS-1:0]       o_root,
    output logic                        o_org
);
    import c2p_pkg::*;

    localparam bit DO_ROT = (IDX < CORDIC_STAGES) && (IDX < TABLE_LEN);
    localparam int TI     = (IDX < TABLE_LEN) ? IDX : 0;
    localparam bit DO_SQ  = IDX < COORD_BITS;
    localparam int K      = DO_SQ ? (COORD_BITS - 1 - IDX) : 0;
    localparam int SQW    = 2 * COORD_BITS;
    localparam int SW     = SQW + 2;

    logic signed [CW-1:0]  n_u;
    logic signed [CW-1:0]  n_v;
    logic [31:0]           n_z;
    logic [SQW-1:0]        n_rem;
    logic [COORD_BITS-1:0] n_root;
    logic [SW-1:0]         trial;

    logic                  r_vld;
    logic signed [CW-1:0]  r_u;
    logic signed [CW-1:0]  r_v;
    logic [31:0]           r_z;
    logic [SQW-1:0]        r_rem;
    logic [COORD_BITS-1:0] r_root;
    logic                  r_org;

    always_comb begin
        n_u = i_u;
        n_v = i_v;
        n_z = i_z;
        if (DO_ROT) begin
            if (i_v >= 0) begin
                n_u = i_u + (i_v >>> IDX);
                n_v = i_v - (i_u >>> IDX);
                n_z = i_z + ATAN_TURN[TI];
            end else begin
                n_u = i_u - (i_v >>> IDX);
                n_v = i_v + (i_u >>> IDX);
                n_z = i_z - ATAN_TURN[TI];
            end
        end
    end

    // Trial subtrahend (2*root*2^K + 2^(2K)) for setting root bit K.
    assign trial = (SW'(i_root) << (K + 1)) + (SW'(1) << (2 * K));

    always_comb begin
        n_rem  = i_rem;
        n_root = i_root;
        if (DO_SQ && (SW'(i_rem) >= trial)) begin
            n_rem  = i_rem - trial[SQW-1:0];
            n_root = i_root | (COORD_BITS'(1) << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_u    <= n_u;
            r_v    <= n_v;
            r_z    <= n_z;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_org  <= i_org;
        end
    end

    assign o_vld  = r_vld;
    assign o_u    = r_u;
    assign o_v    = r_v;
    assign o_z    = r_z;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_org  = r_org;
endmodule

[rtl/c2p_div_cell.sv]
// One cell of the index divider chain: one restoring quotient bit for the
// column and for the ring lane. Depends on c2p_pkg.
module c2p_div_cell #(
    parameter int STEP = 0,
    parameter int QB   = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  c2p_pkg::t_ctl             i_ctl,
    input  logic [c2p_pkg::NUM_W-1:0] i_col_rem,
    input  logic [c2p_pkg::DEN_W-1:0] i_col_den,
    input  logic [QB-1:0]             i_col_q,
    input  c2p_pkg::t_sat             i_col_sat,
    input  logic [c2p_pkg::NUM_W-1:0] i_ring_rem,
    input  logic [c2p_pkg::DEN_W-1:0] i_ring_den,
    input  logic [QB-1:0]             i_ring_q,
    input  c2p_pkg::t_sat             i_ring_sat,
    input  logic                      i_ins,
    output logic                      o_vld,
    output logic [c2p_pkg::NUM_W-1:0] o_col_rem,
    output logic [c2p_pkg::DEN_W-1:0] o_col_den,
    output logic [QB-1:0]             o_col_q,
    output c2p_pkg::t_sat             o_col_sat,
    output logic [c2p_pkg::NUM_W-1:0] o_ring_rem,
    output logic [c2p_pkg::DEN_W-1:0] o_ring_den,
    output logic [QB-1:0]             o_ring_q,
    output c2p_pkg::t_sat             o_ring_sat,
    output logic                      o_ins
);
    import c2p_pkg::*;

    localparam int CMP_W = NUM_W + QB + 1;

    logic [CMP_W-1:0] col_trial;
    logic [CMP_W-1:0] ring_trial;
    logic [NUM_W-1:0] n_col_rem;
    logic [NUM_W-1:0] n_ring_rem;
    logic [QB-1:0]    n_col_q;
    logic [QB-1:0]    n_ring_q;

    logic             r_vld;
    logic [NUM_W-1:0] r_col_rem;
    logic [DEN_W-1:0] r_col_den;
    logic [QB-1:0]    r_col_q;
    t_sat             r_col_sat;
    logic [NUM_W-1:0] r_ring_rem;
    logic [DEN_W-1:0] r_ring_den;
    logic [QB-1:0]    r_ring_q;
    t_sat             r_ring_sat;
    logic             r_ins;

    assign col_trial  = CMP_W'(i_col_den) << STEP;
    assign ring_trial = CMP_W'(i_ring_den) << STEP;

    always_comb begin
        n_col_rem = i_col_rem;
        n_col_q   = i_col_q;
        if (CMP_W'(i_col_rem) >= col_trial) begin
            n_col_rem = i_col_rem - col_trial[NUM_W-1:0];
            n_col_q   = i_col_q | (QB'(1) << STEP);
        end
    end

    always_comb begin
        n_ring_rem = i_ring_rem;
        n_ring_q   = i_ring_q;
        if (CMP_W'(i_ring_rem) >= ring_trial) begin
            n_ring_rem = i_ring_rem - ring_trial[NUM_W-1:0];
            n_ring_q   = i_ring_q | (QB'(1) << STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_col_rem  <= n_col_rem;
            r_col_den  <= i_col_den;
            r_col_q    <= n_col_q;
            r_col_sat  <= i_col_sat;
            r_ring_rem <= n_ring_rem;
            r_ring_den <= i_ring_den;
            r_ring_q   <= n_ring_q;
            r_ring_sat <= i_ring_sat;
            r_ins      <= i_ins;
        end
    end

    assign o_vld      = r_vld;
    assign o_col_rem  = r_col_rem;
    assign o_col_den  = r_col_den;
    assign o_col_q    = r_col_q;
    assign o_col_sat  = r_col_sat;
    assign o_ring_rem = r_ring_rem;
    assign o_ring_den = r_ring_den;
    assign o_ring_q   = r_ring_q;
    assign o_ring_sat = r_ring_sat;
    assign o_ins      = r_ins;
endmodule

[rtl/cartesian_to_polar_cell.sv]
// Bins a signed Cartesian point into a column, a ring and an inside flag of a
// polar wedge grid. One point is accepted in every clock while the output is
// taken; results leave in order. The pipeline has a chain of CORDIC/square-root
// cells (one angle step and one root bit per cell) and a chain of divider cells
// (one quotient bit per cell). When the output is not taken the whole pipeline
// holds. The user must write registers through the configuration channel only
// while no point is in flight; the block itself does not enforce this.
// Depends on c2p_pkg, c2p_in_if, c2p_out_if, c2p_cfg_if, c2p_cell, c2p_div_cell.
module cartesian_to_polar_cell #(
    parameter int MAX_DIM       = 256,
    parameter int COORD_BITS    = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    c2p_in_if.sink     i_pt,
    c2p_cfg_if.sink    i_cfg,
    c2p_out_if.source  o_bin
);
    import c2p_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int CW    = C + PRESCALE_SH + 3;
    localparam int N     = (CORDIC_STAGES > C) ? CORDIC_STAGES : C;
    localparam int QB    = $clog2(MAX_DIM + 1);
    localparam int SQW   = 2 * C;
    localparam int MC    = (C > 15) ? C : 15;
    localparam int NRW   = MC + 2;
    localparam int NCW   = 34;
    localparam int PCW   = NCW + 10;
    localparam int PRW   = NRW + 10;
    localparam int RW    = MC + 8;
    localparam int CMP_W = NUM_W + QB + 1;
    localparam logic [31:0] RND_HALF = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [31:0] RND_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // Configuration registers.
    logic [15:0] r_rot;
    logic [15:0] r_hw;
    logic [14:0] r_rad;
    logic [8:0]  r_cols;
    logic [8:0]  r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot  <= RST_ROTATION;
            r_hw   <= RST_HALF_WIDTH;
            r_rad  <= RST_OUTER_RAD;
            r_cols <= RST_COLUMNS;
            r_rows <= RST_ROWS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_ROTATION:   r_rot  <= i_cfg.data;
                CFG_HALF_WIDTH: r_hw   <= i_cfg.data;
                CFG_OUTER_RAD:  r_rad  <= i_cfg.data[14:0];
                CFG_COLUMNS:    r_cols <= i_cfg.data[8:0];
                CFG_ROWS:       r_rows <= i_cfg.data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    logic [15:0] hw1;
    logic [14:0] rad1;
    assign hw1  = (r_hw == 16'd0) ? 16'd1 : r_hw;
    assign rad1 = (r_rad == 15'd0) ? 15'd1 : r_rad;

    logic r_out_vld;
    logic adv;
    assign adv        = !r_out_vld || o_bin.ready;
    assign i_pt.ready = adv;

    // Stage A: squares.
    logic signed [SQW-1:0] ex;
    logic signed [SQW-1:0] ey;
    logic signed [SQW-1:0] n_a_xx;
    logic signed [SQW-1:0] n_a_yy;
    logic                  r_a_vld;
    logic signed [C-1:0]   r_a_x;
    logic signed [C-1:0]   r_a_y;
    logic [SQW-1:0]        r_a_xx;
    logic [SQW-1:0]        r_a_yy;

    assign ex     = SQW'(i_pt.x_pos);
    assign ey     = SQW'(i_pt.y_pos);
    assign n_a_xx = ex * ex;
    assign n_a_yy = ey * ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_x  <= i_pt.x_pos;
            r_a_y  <= i_pt.y_pos;
            r_a_xx <= n_a_xx;
            r_a_yy <= n_a_yy;
        end
    end

    // Stage B: sum of squares and the half-turn fold for y < 0.
    logic signed [CW-1:0] pre_u;
    logic signed [CW-1:0] pre_v;
    logic signed [CW-1:0] n_b_u;
    logic signed [CW-1:0] n_b_v;
    logic [31:0]          n_b_z;
    logic                 r_b_vld;
    logic signed [CW-1:0] r_b_u;
    logic signed [CW-1:0] r_b_v;
    logic [31:0]          r_b_z;
    logic [SQW-1:0]       r_b_sq;
    logic                 r_b_org;

    assign pre_u = CW'(r_a_y) <<< PRESCALE_SH;
    assign pre_v = CW'(r_a_x) <<< PRESCALE_SH;

    always_comb begin
        n_b_u = pre_u;
        n_b_v = pre_v;
        n_b_z = 32'd0;
        if (r_a_y < 0) begin
            n_b_u = -pre_u;
            n_b_v = -pre_v;
            n_b_z = 32'h8000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_u   <= n_b_u;
            r_b_v   <= n_b_v;
            r_b_z   <= n_b_z;
            r_b_sq  <= r_a_xx + r_a_yy;
            r_b_org <= (r_a_x == '0) && (r_a_y == '0);
        end
    end

    // Chain of CORDIC / square-root cells.
    logic                 c_vld  [N+1];
    logic signed [CW-1:0] c_u    [N+1];
    logic signed [CW-1:0] c_v    [N+1];
    logic [31:0]          c_z    [N+1];
    logic [SQW-1:0]       c_rem  [N+1];
    logic [C-1:0]         c_root [N+1];
    logic                 c_org  [N+1];

    assign c_vld[0]  = r_b_vld;
    assign c_u[0]    = r_b_u;
    assign c_v[0]    = r_b_v;
    assign c_z[0]    = r_b_z;
    assign c_rem[0]  = r_b_sq;
    assign c_root[0] = '0;
    assign c_org[0]  = r_b_org;

    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        t_ctl ctl;
        assign ctl.adv = adv;
        assign ctl.vld = c_vld[gi];
        c2p_cell #(
            .IDX           (gi),
            .COORD_BITS    (C),
            .CORDIC_STAGES (CORDIC_STAGES),
            .CW            (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_u     (c_u[gi]),
            .i_v     (c_v[gi]),
            .i_z     (c_z[gi]),
            .i_rem   (c_rem[gi]),
            .i_root  (c_root[gi]),
            .i_org   (c_org[gi]),
            .o_vld   (c_vld[gi+1]),
            .o_u     (c_u[gi+1]),
            .o_v     (c_v[gi+1]),
            .o_z     (c_z[gi+1]),
            .o_rem   (c_rem[gi+1]),
            .o_root  (c_root[gi+1]),
            .o_org   (c_org[gi+1])
        );
    end

    // P1: round the angle and take the wrapped offset from the wedge centre.
    logic [31:0]        p1_a;
    logic [31:0]        p1_d;
    logic signed [32:0] n_p1_da;
    logic               r_p1_vld;
    logic signed [32:0] r_p1_da;
    logic [C-1:0]       r_p1_r;
    logic               r_p1_org;

    assign p1_a    = c_org[N] ? 32'd0 : ((c_z[N] + RND_HALF) & RND_MASK);
    assign p1_d    = p1_a - {r_rot, 16'h0000};
    assign n_p1_da = (p1_d > 32'h8000_0000) ? $signed({1'b1, p1_d}) : $signed({1'b0, p1_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (adv) begin
            r_p1_vld <= c_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_da  <= n_p1_da;
            r_p1_r   <= c_root[N];
            r_p1_org <= c_org[N];
        end
    end

    // P2: numerator terms and the inside flag.
    logic signed [NCW-1:0] p2_h;
    logic [32:0]           p2_adiff;
    logic [RW-1:0]         p2_r100;
    logic [RW-1:0]         p2_rad101;
    logic                  n_p2_ins;
    logic                  r_p2_vld;
    logic signed [NCW-1:0] r_p2_nc;
    logic signed [NRW-1:0] r_p2_nr;
    logic                  r_p2_ins;

    assign p2_h      = NCW'($signed({1'b0, hw1, 16'h0000}));
    assign p2_adiff  = (r_p1_da < 0) ? 33'(-r_p1_da) : 33'(r_p1_da);
    assign p2_r100   = RW'(r_p1_r) * RW'(100);
    assign p2_rad101 = RW'(rad1) * RW'(101);

    always_comb begin
        if (r_p1_org) begin
            n_p2_ins = 1'b1;
        end else if (p2_r100 > p2_rad101) begin
            n_p2_ins = 1'b0;
        end else begin
            n_p2_ins = p2_adiff <= {1'b0, hw1, 16'h0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (adv) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_nc  <= NCW'(r_p1_da) + p2_h;
            r_p2_nr  <= NRW'($signed({1'b0, rad1})) - NRW'($signed({1'b0, r_p1_r}));
            r_p2_ins <= n_p2_ins;
        end
    end

    // P3: scale by the grid size.
    logic                  r_p3_vld;
    logic signed [PCW-1:0] r_p3_pc;
    logic signed [PRW-1:0] r_p3_pr;
    logic                  r_p3_ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (adv) begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_pc  <= PCW'(r_p2_nc) * PCW'($signed({1'b0, r_cols}));
            r_p3_pr  <= PRW'(r_p2_nr) * PRW'($signed({1'b0, r_rows}));
            r_p3_ins <= r_p2_ins;
        end
    end

    // P4: sign and overflow screening ahead of the divider chain. A negative
    // numerator always floors to -1 or below; a quotient of 2^QB or more is
    // above MAX_DIM.
    logic [NUM_W-1:0] p4_cn;
    logic [NUM_W-1:0] p4_rn;
    logic [DEN_W-1:0] p4_cd;
    logic [DEN_W-1:0] p4_rd;
    t_sat             p4_cs;
    t_sat             p4_rs;

    assign p4_cn = NUM_W'(r_p3_pc);
    assign p4_rn = NUM_W'(r_p3_pr);
    assign p4_cd = {hw1, 17'h00000};
    assign p4_rd = DEN_W'(rad1);

    always_comb begin
        if (r_p3_pc < 0) begin
            p4_cs = SAT_LOW;
        end else if (CMP_W'(p4_cn) >= (CMP_W'(p4_cd) << QB)) begin
            p4_cs = SAT_HIGH;
        end else begin
            p4_cs = SAT_NONE;
        end
        if (r_p3_pr < 0) begin
            p4_rs = SAT_LOW;
        end else if (CMP_W'(p4_rn) >= (CMP_W'(p4_rd) << QB)) begin
            p4_rs = SAT_HIGH;
        end else begin
            p4_rs = SAT_NONE;
        end
    end

    logic             r_p4_vld;
    logic [NUM_W-1:0] r_p4_cn;
    logic [NUM_W-1:0] r_p4_rn;
    logic [DEN_W-1:0] r_p4_cd;
    logic [DEN_W-1:0] r_p4_rd;
    t_sat             r_p4_cs;
    t_sat             r_p4_rs;
    logic             r_p4_ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else if (adv) begin
            r_p4_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p4_cn  <= p4_cn;
            r_p4_rn  <= p4_rn;
            r_p4_cd  <= p4_cd;
            r_p4_rd  <= p4_rd;
            r_p4_cs  <= p4_cs;
            r_p4_rs  <= p4_rs;
            r_p4_ins <= r_p3_ins;
        end
    end

    // Divider chain, most significant quotient bit first.
    logic             d_vld  [QB+1];
    logic [NUM_W-1:0] d_crem [QB+1];
    logic [DEN_W-1:0] d_cden [QB+1];
    logic [QB-1:0]    d_cq   [QB+1];
    t_sat             d_csat [QB+1];
    logic [NUM_W-1:0] d_rrem [QB+1];
    logic [DEN_W-1:0] d_rden [QB+1];
    logic [QB-1:0]    d_rq   [QB+1];
    t_sat             d_rsat [QB+1];
    logic             d_ins  [QB+1];

    assign d_vld[0]  = r_p4_vld;
    assign d_crem[0] = r_p4_cn;
    assign d_cden[0] = r_p4_cd;
    assign d_cq[0]   = '0;
    assign d_csat[0] = r_p4_cs;
    assign d_rrem[0] = r_p4_rn;
    assign d_rden[0] = r_p4_rd;
    assign d_rq[0]   = '0;
    assign d_rsat[0] = r_p4_rs;
    assign d_ins[0]  = r_p4_ins;

    for (genvar gj = 0; gj < QB; gj++) begin : g_div
        t_ctl ctl;
        assign ctl.adv = adv;
        assign ctl.vld = d_vld[gj];
        c2p_div_cell #(
            .STEP (QB - 1 - gj),
            .QB   (QB)
        ) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_col_rem  (d_crem[gj]),
            .i_col_den  (d_cden[gj]),
            .i_col_q    (d_cq[gj]),
            .i_col_sat  (d_csat[gj]),
            .i_ring_rem (d_rrem[gj]),
            .i_ring_den (d_rden[gj]),
            .i_ring_q   (d_rq[gj]),
            .i_ring_sat (d_rsat[gj]),
            .i_ins      (d_ins[gj]),
            .o_vld      (d_vld[gj+1]),
            .o_col_rem  (d_crem[gj+1]),
            .o_col_den  (d_cden[gj+1]),
            .o_col_q    (d_cq[gj+1]),
            .o_col_sat  (d_csat[gj+1]),
            .o_ring_rem (d_rrem[gj+1]),
            .o_ring_den (d_rden[gj+1]),
            .o_ring_q   (d_rq[gj+1]),
            .o_ring_sat (d_rsat[gj+1]),
            .o_ins      (d_ins[gj+1])
        );
    end

    function automatic logic [OUT_W-1:0] sat_index(input t_sat sat, input logic [QB-1:0] q);
        logic signed [31:0] val;
        begin
            case (sat)
                SAT_NONE: val = (32'(q) > MAX_DIM) ? 32'(MAX_DIM) : 32'(q);
                SAT_LOW:  val = -32'sd1;
                SAT_HIGH: val = 32'(MAX_DIM);
                default:  val = -32'sd1;
            endcase
            sat_index = val[OUT_W-1:0];
        end
    endfunction

    // Output register.
    logic [OUT_W-1:0] r_col;
    logic [OUT_W-1:0] r_ring;
    logic             r_ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= d_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_col  <= sat_index(d_csat[QB], d_cq[QB]);
            r_ring <= sat_index(d_rsat[QB], d_rq[QB]);
            r_ins  <= d_ins[QB];
        end
    end

    assign o_bin.valid      = r_out_vld;
    assign o_bin.column     = r_col;
    assign o_bin.ring       = r_ring;
    assign o_bin.inside_res = r_ins;

    // A stalled output freezes the whole pipeline.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin.valid && !o_bin.ready) |=> ($stable(r_b_vld) && $stable(r_p4_vld)))
        else $error("pipeline moved while output stalled");

    // An accepted point always occupies the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> r_a_vld)
        else $error("accepted point lost at first stage");

    // A negative index can only be the low saturation value.
    a_low_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin.valid && o_bin.column[OUT_W-1] && (MAX_DIM < 512))
            |-> (o_bin.column == '1))
        else $error("negative column other than -1");
endmodule

[verif/c2p_bin_checker.sv]
// Checker for the polar wedge cell binning block: watches the point, configuration
// and result channels, predicts each cell and compares it with the block's output.
// Depends on c2p_pkg, c2p_in_if, c2p_out_if and c2p_cfg_if.
module c2p_bin_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    c2p_in_if    pt_mon,
    c2p_cfg_if   cfg_mon,
    c2p_out_if   bin_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import c2p_pkg::*;

    typedef struct packed {
        logic signed [9:0] column;
        logic signed [9:0] ring;
        logic              inside_res;
    } t_cell;

    logic [15:0] rotation_q;
    logic [15:0] half_width_q;
    logic [14:0] outer_rad_q;
    logic [8:0]  columns_q;
    logic [8:0]  rows_q;

    t_cell cell_queue[$];
    int    fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = cell_queue.size();

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s    = s - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC on a 2^32 full-turn scale, angle measured clockwise from +Y.
    function automatic logic [31:0] turn_angle(input longint x, input longint y);
        longint      u;
        longint      v;
        longint      du;
        longint      dv;
        logic [31:0] z;
        if (x == 0 && y == 0) return 32'd0;
        u = y * 64'sd16777216;
        v = x * 64'sd16777216;
        z = 32'd0;
        if (u < 0) begin
            u = -u;
            v = -v;
            z = 32'h80000000;
        end
        for (int i = 0; i < 16; i++) begin
            du = v >>> i;
            dv = u >>> i;
            if (v >= 0) begin
                u = u + du;
                v = v - dv;
                z = z + ATAN_TURN[i];
            end else begin
                u = u - du;
                v = v + dv;
                z = z - ATAN_TURN[i];
            end
        end
        return z;
    endfunction

    function automatic longint div_floor(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [9:0] clamp_index(input longint v);
        if (v < -1) return -10'sd1;
        if (v > 256) return 10'sd256;
        return v[9:0];
    endfunction

    function automatic t_cell bin_point(input logic signed [15:0] xs,
                                        input logic signed [15:0] ys);
        longint      x;
        longint      y;
        longint      r;
        logic [31:0] z;
        logic [31:0] a;
        logic [31:0] d;
        longint      da;
        longint      h;
        longint      rad;
        longint      adiff;
        t_cell       res;
        x  = xs;
        y  = ys;
        r  = longint'(int_sqrt(longint'(x * x + y * y)));
        z  = turn_angle(x, y);
        a  = (z + 32'h00008000) & 32'hFFFF0000;
        d  = a - {rotation_q, 16'd0};
        da = (d > 32'h80000000) ? longint'(d) - 64'sd4294967296 : longint'(d);
        h  = longint'((half_width_q == 0) ? 16'd1 : half_width_q) << 16;
        rad = (outer_rad_q == 0) ? 1 : longint'(outer_rad_q);
        res.column = clamp_index(div_floor((da + h) * longint'(columns_q), 2 * h));
        res.ring   = clamp_index(div_floor((rad - r) * longint'(rows_q), rad));
        adiff = (da < 0) ? -da : da;
        if (x == 0 && y == 0)      res.inside_res = 1'b1;
        else if (r * 100 > rad * 101) res.inside_res = 1'b0;
        else                       res.inside_res = (adiff <= h);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cell want;
        if (!i_rst_n) begin
            rotation_q   <= RST_ROTATION;
            half_width_q <= RST_HALF_WIDTH;
            outer_rad_q  <= RST_OUTER_RAD;
            columns_q    <= RST_COLUMNS;
            rows_q       <= RST_ROWS;
            cell_queue.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    CFG_ROTATION:   rotation_q   <= cfg_mon.data;
                    CFG_HALF_WIDTH: half_width_q <= cfg_mon.data;
                    CFG_OUTER_RAD:  outer_rad_q  <= cfg_mon.data[14:0];
                    CFG_COLUMNS:    columns_q    <= cfg_mon.data[8:0];
                    CFG_ROWS:       rows_q       <= cfg_mon.data[8:0];
                    default: ;
                endcase
            end
            if (pt_mon.valid && pt_mon.ready)
                cell_queue.insert(cell_queue.size(), bin_point(pt_mon.x_pos, pt_mon.y_pos));
            if (bin_mon.valid && bin_mon.ready) begin
                if (cell_queue.size() == 0) begin
                    $display("%0t: unexpected result column %0d ring %0d inside %0d",
                             $time, bin_mon.column, bin_mon.ring, bin_mon.inside_res);
                    fail_count++;
                end else begin
                    want = cell_queue.pop_front();
                    if (bin_mon.column !== want.column) begin
                        $display("%0t: column expected %0d actual %0d",
                                 $time, want.column, bin_mon.column);
                        fail_count++;
                    end
                    if (bin_mon.ring !== want.ring) begin
                        $display("%0t: ring expected %0d actual %0d",
                                 $time, want.ring, bin_mon.ring);
                        fail_count++;
                    end
                    if (bin_mon.inside_res !== want.inside_res) begin
                        $display("%0t: inside expected %0d actual %0d",
                                 $time, want.inside_res, bin_mon.inside_res);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

[verif/tb_top.sv]
// Testbench top for cartesian_to_polar_cell: drives points and register writes
// with random idling, and gives the verdict from the checker's failure count.
// Depends on c2p_pkg, the channel interfaces, the block and c2p_bin_checker.
module tb_top;
    import c2p_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   fail_count;
    int   pending;
    int   cur_rad = 16384;

    c2p_in_if  pt_if();
    c2p_cfg_if cfg_if();
    c2p_out_if bin_if();

    assign bin_if.ready = sink_ready;

    cartesian_to_polar_cell dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .i_cfg   (cfg_if),
        .o_bin   (bin_if)
    );

    c2p_bin_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pt_mon       (pt_if),
        .cfg_mon      (cfg_if),
        .bin_mon      (bin_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
        logic rdy;
        pt_if.valid <= 1'b1;
        pt_if.x_pos <= x;
        pt_if.y_pos <= y;
        forever begin
            @(negedge i_clk);
            rdy = pt_if.ready;
            @(posedge i_clk);
            if (rdy) break;
        end
        if (!quiet && $urandom_range(0, 9) == 0) begin
            pt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Leaves valid high so that writes can follow back to back; the caller
    // drops it after the last write of a group.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic rdy;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        forever begin
            @(negedge i_clk);
            rdy = cfg_if.ready;
            @(posedge i_clk);
            if (rdy) break;
        end
        if (idx == CFG_OUTER_RAD) cur_rad = (value[14:0] == 0) ? 1 : value[14:0];
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [15:0] rot, input logic [15:0] hw,
                            input logic [15:0] rad, input logic [15:0] cols,
                            input logic [15:0] rows);
        write_reg(CFG_ROTATION, rot);
        write_reg(CFG_HALF_WIDTH, hw);
        write_reg(CFG_OUTER_RAD, rad);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
    endtask

    task automatic random_point();
        int x;
        int y;
        int lim;
        case ($urandom_range(0, 2))
            0: begin
                x = $signed(16'($urandom));
                y = $signed(16'($urandom));
            end
            1: begin
                x = $urandom_range(0, 64) - 32;
                y = $urandom_range(0, 64) - 32;
            end
            default: begin
                // Around the outer edge, where the tolerance test matters.
                lim = cur_rad + cur_rad / 50 + 2;
                if (lim > 32767) lim = 32767;
                x = $urandom_range(0, 2 * lim) - lim;
                y = $urandom_range(0, 2 * lim) - lim;
            end
        endcase
        send_point(x[15:0], y[15:0]);
    endtask

    initial begin
        pt_if.valid  = 1'b0;
        pt_if.x_pos  = '0;
        pt_if.y_pos  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at reset settings: origin, corners, axes, edge tolerance.
        send_point(16'sd0, 16'sd0);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767);
        send_point(16'sd32767, -16'sd32768);
        send_point(16'sd0, -16'sd32768);
        send_point(16'sd0, 16'sd32767);
        send_point(16'sd32767, 16'sd0);
        send_point(-16'sd32768, 16'sd0);
        send_point(16'sd1, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(-16'sd1, 16'sd0);
        send_point(16'sd0, -16'sd1);
        send_point(-16'sd1, -16'sd1);
        send_point(16'sd0, 16'sd16384);
        send_point(16'sd0, 16'sd16547);
        send_point(16'sd0, 16'sd16548);
        send_point(16'sd11585, 16'sd11585);
        send_point(-16'sd11586, 16'sd11585);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: set_grid(16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
                1: set_grid(16'd65535, 16'd32768, 16'd32767, 16'd256, 16'd256);
                2: set_grid(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                3: set_grid(16'd49152, 16'd65535, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: begin
                    set_grid(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
                    // Unknown indexes must leave the grid alone.
                    write_reg(3'd5 + 3'($urandom_range(0, 2)), 16'($urandom));
                end
            endcase
            cfg_if.valid <= 1'b0;
            if (phase == 9) quiet = 1'b1;
            send_point(16'sd0, 16'sd0);
            send_point(16'sd0, 16'(cur_rad));
            repeat (150) random_point();
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top failed");
        $finish;
    end
endmodule

[sim.f]
rtl/c2p_pkg.sv
rtl/c2p_in_if.sv
rtl/c2p_out_if.sv
rtl/c2p_cfg_if.sv
rtl/c2p_cell.sv
rtl/c2p_div_cell.sv
rtl/cartesian_to_polar_cell.sv
verif/c2p_bin_checker.sv
verif/tb_top.sv
